[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks on a clocked design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/skdrc_pkg.sv]
// ----------------------------------------------------------------------------
// skdrc_pkg
// Types, constants and table generators for the soft-knee compressor.
// ----------------------------------------------------------------------------
package skdrc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // divider widths: quotient is known to stay below 2^DIV_Q_W
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 31;
    localparam int DIV_Q_W   = 18;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    // fixed-point constants
    localparam logic [19:0] DB_PER_OCT_Q16 = 20'd394566;
    localparam logic [14:0] OCT_PER_DB_Q16 = 15'd10885;
    localparam longint unsigned LN2_Q32    = 64'd2977044472;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_RATIO     = 3'd1,
        REG_KNEE      = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_DECAY     = 3'd4,
        REG_BOOST     = 3'd5
    } t_cfg_reg;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } t_div_rsp;

    // log2(1 + f) in Q0.16 by repeated squaring, v is 1+f in Q2.30
    function automatic logic [15:0] log2_entry(input longint unsigned v0);
        longint unsigned v;
        logic [15:0]     r;
        v = v0;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            v = (v * v) >> 30;
            if (v >= (64'd1 << 31)) begin
                v    = v >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // e^-t in Q1.16 by a series through the t^16 term, t in Q0.32
    function automatic logic [16:0] exp_entry(input longint unsigned t);
        longint unsigned sum;
        longint unsigned term;
        longint unsigned res;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * t) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        res = (sum + 64'd32768) >> 16;
        return res[16:0];
    endfunction

endpackage

[rtl/core/skdrc_mul.sv]
// ----------------------------------------------------------------------------
// skdrc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module skdrc_mul (
    input  logic                                 i_clk,
    input  logic signed [skdrc_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [skdrc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [skdrc_pkg::MUL_P_W-1:0] o_prod
);
    import skdrc_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    // register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/skdrc_div.sv]
// ----------------------------------------------------------------------------
// skdrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skdrc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  skdrc_pkg::t_div_req   i_req,
    output skdrc_pkg::t_div_rsp   o_rsp
);
    import skdrc_pkg::*;

    localparam int SH_W = DIV_DEN_W + DIV_Q_W;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [SH_W-1:0]      w_sub;
    logic                 w_fit;

    // trial subtrahend for the current quotient bit
    assign w_sub = SH_W'(r_den) << r_cnt;
    assign w_fit = SH_W'(r_rem) >= w_sub;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: subtract when the shifted divisor fits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
            r_cnt <= DIV_CNT_W'(DIV_Q_W - 1);
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem        <= DIV_NUM_W'(SH_W'(r_rem) - w_sub);
                r_quo[r_cnt] <= 1'b1;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[rtl/core/soft_knee_dynamic_range_compressor.sv]
// ----------------------------------------------------------------------------
// soft_knee_dynamic_range_compressor
// Feedforward log-domain compressor with soft knee and peak smoothing.
// ----------------------------------------------------------------------------
// One sample at a time: a sample is taken, worked through a sequencer that
// drives one shared registered multiplier and an iterative divider, and
// gives one saturated sample. Below the knee the divider is skipped; above
// and inside it the sequencer waits for the 18-step divider, and inside it
// more multiply steps come first. A rising smoothed reduction takes the
// attack steps, a falling one the decay step. Input ready is low while a
// sample is worked. A finished sample waits in an output register, and the
// next sample is taken while it waits; a sample that finishes while the
// output register is still full waits in the last step. Configuration
// writes take effect at once and must come while the block is idle.
module soft_knee_dynamic_range_compressor #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int LOG_TABLE_DEPTH = 256,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [skdrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [15:0]                           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_in_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        o_out_sample
);
    import skdrc_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int NW   = (SW > 16) ? SW : 16;
    localparam int EW   = $clog2(SW);
    localparam int LAW  = $clog2(LOG_TABLE_DEPTH);
    localparam int EAW  = $clog2(EXP_TABLE_DEPTH);
    localparam logic [SW-1:0] OFF = SW'(((64'd1 << (SW - 1)) + 64'd50) / 64'd100);
    localparam int YW   = SW + 36;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_LRD, S_XG, S_DIFF, S_K2, S_K3, S_K4, S_HARD, S_DIV,
        S_SMOOTH, S_ATK1, S_ATK2, S_DEC, S_GAIN, S_EIDX, S_ERD, S_GSH,
        S_Y1, S_Y2, S_Y3
    } t_state;

    // constant tables
    logic [15:0] w_log_tab [LOG_TABLE_DEPTH];
    logic [16:0] w_exp_tab [EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_log
        localparam longint unsigned V0 =
            ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / LOG_TABLE_DEPTH;
        assign w_log_tab[gi] = log2_entry(V0);
    end

    for (genvar gj = 0; gj < EXP_TABLE_DEPTH; gj++) begin : g_exp
        localparam longint unsigned T0 = (64'(gj) * LN2_Q32) / EXP_TABLE_DEPTH;
        assign w_exp_tab[gj] = exp_entry(T0);
    end

    // registers
    t_state                    r_state;
    logic signed [15:0]        r_thr;
    logic [13:0]               r_ratio;
    logic [12:0]               r_knee;
    logic [15:0]               r_attack;
    logic [15:0]               r_decay;
    logic [15:0]               r_boost;
    logic [15:0]               r_st;
    logic signed [SW-1:0]      r_x;
    logic [EW-1:0]             r_e;
    logic [15:0]               r_lt;
    logic [14:0]               r_s2;
    logic [DIV_NUM_W-1:0]      r_num;
    logic [17:0]               r_red;
    logic signed [MUL_P_W-1:0] r_acc;
    logic [5:0]                r_q;
    logic [16:0]               r_et;
    logic [15:0]               r_bg_hi;
    logic                      r_out_valid;
    logic signed [SW-1:0]      r_out;

    // shared units
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [MUL_P_W-1:0] w_prod;
    t_div_req                  w_dreq;
    t_div_rsp                  w_drsp;

    skdrc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    skdrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // level: |x| + offset, normalized to a 15-bit fraction
    logic [SW-1:0]        w_ax;
    logic [SW-1:0]        w_lvl;
    logic [EW-1:0]        w_e;
    logic [NW-1:0]        w_norm;
    logic [14:0]          w_frac;

    always_comb begin
        w_ax  = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
        w_lvl = w_ax + OFF;
        w_e   = '0;
        for (int k = 0; k < SW; k++) begin
            if (w_lvl[k]) begin
                w_e = EW'(k);
            end
        end
        w_norm = NW'(w_lvl) << (NW - 1 - int'(w_e));
        w_frac = w_norm[NW-2 -: 15];
    end

    // static curve terms
    logic [13:0]          w_ratio;
    logic signed [31:0]   w_l;
    logic signed [19:0]   w_xg;
    logic signed [20:0]   w_d;
    logic signed [21:0]   w_d2;
    logic signed [21:0]   w_w;
    logic                 w_below;
    logic                 w_in_knee;
    logic [21:0]          w_s2;

    assign w_ratio   = (r_ratio < 14'd256) ? 14'd256 : r_ratio;
    assign w_l       = 32'((int'(r_e) - (SW - 1)) * 65536) + 32'(r_lt);
    assign w_xg      = w_prod[43:24];
    assign w_d       = 21'(w_xg) - 21'(r_thr);
    assign w_d2      = 22'(w_d) <<< 1;
    assign w_w       = $signed({9'd0, r_knee});
    assign w_below   = w_d2 < -w_w;
    assign w_in_knee = (r_knee != '0) && (w_d2 <= w_w);
    assign w_s2      = 22'(w_d2 + w_w);

    // smoothing and output terms
    logic signed [MUL_P_W-1:0] w_sum;
    logic [35:0]               w_st_full;
    logic [15:0]               w_st_new;
    logic [16:0]               w_g;
    logic signed [YW-1:0]      w_tot;
    logic signed [YW-29:0]     w_y;
    logic signed [SW-1:0]      w_y_sat;

    always_comb begin
        w_sum     = r_acc + w_prod;
        w_st_full = w_sum[51:16];
        w_st_new  = (w_st_full > 36'd65535) ? 16'hFFFF : w_st_full[15:0];
        w_g       = (r_q >= 6'd32) ? 17'd0 : 17'(r_et >> r_q);
        w_tot     = YW'(r_acc) + (YW'(w_prod) <<< 16);
        w_y       = w_tot[YW-1:28];
        if (w_y > (YW-28)'(2 ** (SW - 1) - 1)) begin
            w_y_sat = {1'b0, {(SW-1){1'b1}}};
        end else if (w_y < -((YW-28)'(2 ** (SW - 1)))) begin
            w_y_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_y_sat = w_y[SW-1:0];
        end
    end

    // multiplier operands and divider request per step
    always_comb begin
        w_ma        = '0;
        w_mb        = '0;
        w_dreq      = '0;
        case (r_state)
            S_NORM: begin
                w_ma = $signed({17'd0, w_frac});
                w_mb = MUL_B_W'(LOG_TABLE_DEPTH);
            end
            S_XG: begin
                w_ma = w_l;
                w_mb = $signed(DB_PER_OCT_Q16);
            end
            S_DIFF: begin
                if (w_in_knee) begin
                    w_ma = $signed({18'd0, w_ratio - 14'd256});
                    w_mb = $signed({5'd0, w_s2[14:0]});
                end else begin
                    w_ma = 32'(w_d);
                    w_mb = $signed({6'd0, w_ratio - 14'd256});
                end
            end
            S_K2: begin
                w_ma = $signed({3'd0, w_prod[28:0]});
                w_mb = $signed({5'd0, r_s2});
            end
            S_K3: begin
                w_ma = $signed({18'd0, w_ratio});
                w_mb = $signed({7'd0, r_knee});
            end
            S_K4: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = r_num;
                w_dreq.den   = DIV_DEN_W'(w_prod[27:0]) << 3;
            end
            S_HARD: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = DIV_NUM_W'(w_prod[42:0]);
                w_dreq.den   = DIV_DEN_W'(w_ratio);
            end
            S_SMOOTH: begin
                if (r_red > 18'(r_st)) begin
                    w_ma = $signed({16'd0, r_attack});
                end else begin
                    w_ma = $signed({16'd0, r_decay});
                end
                w_mb = $signed({4'd0, r_st});
            end
            S_ATK1: begin
                w_ma = $signed(32'd65536 - {16'd0, r_attack});
                w_mb = $signed({2'd0, r_red});
            end
            S_GAIN: begin
                w_ma = $signed({16'd0, r_st});
                w_mb = $signed({5'd0, OCT_PER_DB_Q16});
            end
            S_EIDX: begin
                w_ma = $signed({16'd0, w_prod[23:8]});
                w_mb = MUL_B_W'(EXP_TABLE_DEPTH);
            end
            S_GSH: begin
                w_ma = $signed({16'd0, r_boost});
                w_mb = $signed({3'd0, w_g});
            end
            S_Y1: begin
                w_ma = 32'(r_x);
                w_mb = $signed({4'd0, w_prod[15:0]});
            end
            // keep the high partial product while the result waits
            S_Y2, S_Y3: begin
                w_ma = 32'(r_x);
                w_mb = $signed({4'd0, r_bg_hi});
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    // sequencer, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_st        <= '0;
            r_thr       <= -16'sd5120;
            r_ratio     <= 14'd1024;
            r_knee      <= 13'd1536;
            r_attack    <= 16'd58982;
            r_decay     <= 16'd65208;
            r_boost     <= 16'd4096;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: r_thr    <= $signed(i_cfg_data);
                    REG_RATIO:     r_ratio  <= i_cfg_data[13:0];
                    REG_KNEE:      r_knee   <= i_cfg_data[12:0];
                    REG_ATTACK:    r_attack <= i_cfg_data;
                    REG_DECAY:     r_decay  <= i_cfg_data;
                    REG_BOOST:     r_boost  <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the output beat once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && r_state != S_Y3) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_in_sample;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_e     <= w_e;
                    r_state <= S_LRD;
                end
                S_LRD: begin
                    r_lt    <= w_log_tab[w_prod[15 +: LAW]];
                    r_state <= S_XG;
                end
                S_XG: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_s2 <= w_s2[14:0];
                    if (w_below) begin
                        r_red   <= '0;
                        r_state <= S_SMOOTH;
                    end else if (w_in_knee) begin
                        r_state <= S_K2;
                    end else begin
                        r_state <= S_HARD;
                    end
                end
                S_K2: begin
                    r_state <= S_K3;
                end
                S_K3: begin
                    r_num   <= DIV_NUM_W'(w_prod[42:0]);
                    r_state <= S_K4;
                end
                S_K4: begin
                    r_state <= S_DIV;
                end
                S_HARD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_red   <= w_drsp.quo;
                        r_state <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    r_state <= (r_red > 18'(r_st)) ? S_ATK1 : S_DEC;
                end
                S_ATK1: begin
                    r_acc   <= w_prod;
                    r_state <= S_ATK2;
                end
                S_ATK2: begin
                    r_st    <= w_st_new;
                    r_state <= S_GAIN;
                end
                S_DEC: begin
                    r_st    <= w_prod[31:16];
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_state <= S_EIDX;
                end
                S_EIDX: begin
                    r_q     <= w_prod[29:24];
                    r_state <= S_ERD;
                end
                S_ERD: begin
                    r_et    <= w_exp_tab[w_prod[16 +: EAW]];
                    r_state <= S_GSH;
                end
                S_GSH: begin
                    r_state <= S_Y1;
                end
                S_Y1: begin
                    r_bg_hi <= w_prod[31:16];
                    r_state <= S_Y2;
                end
                S_Y2: begin
                    r_acc   <= w_prod;
                    r_state <= S_Y3;
                end
                S_Y3: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= w_y_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out;

endmodule

[rtl/core/skdrc_chk.sv]
// ----------------------------------------------------------------------------
// skdrc_chk
// Port-level checks for the compressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skdrc_chk #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_sample
);

    // a stalled output beat holds its value
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_sample))

    // an accepted sample occupies the block for the next cycle
    `ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a new result appears only at the end of work on a sample
    `ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind soft_knee_dynamic_range_compressor skdrc_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_skdrc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_sample (o_out_sample)
);
